// ----- rtl/pcd_pkg.sv -----
package pcd_pkg;

  // Section codes, as they appear on the section output
  localparam logic [2:0] SEC_SIG  = 3'd0;
  localparam logic [2:0] SEC_LEN  = 3'd1;
  localparam logic [2:0] SEC_TYPE = 3'd2;
  localparam logic [2:0] SEC_DATA = 3'd3;
  localparam logic [2:0] SEC_CRC  = 3'd4;

  // Known chunk types; the index is the type code
  localparam int unsigned NumKnown = 11;
  localparam logic [3:0] TYPE_UNKNOWN = 4'd11;

  localparam logic [31:0] KNOWN_TYPES [NumKnown] = '{
    32'h49484452,  // IHDR
    32'h504C5445,  // PLTE
    32'h49444154,  // IDAT
    32'h49454E44,  // IEND
    32'h6348524D,  // cHRM
    32'h624B4744,  // bKGD
    32'h74455874,  // tEXt
    32'h67414D41,  // gAMA
    32'h70485973,  // pHYs
    32'h74494D45,  // tIME
    32'h7A545874   // zTXt
  };

  // Property bit within each type byte
  localparam int unsigned PropBit = 5;

  // Per-byte framing result from the tracker
  typedef struct packed {
    logic [2:0]  section;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        chunk_end;
  } step_t;

  // Type classification result
  typedef struct packed {
    logic [3:0] type_code;
    logic       ancillary;
    logic       priv;
    logic       reserved;
    logic       safe_copy;
  } class_t;

endpackage

// ----- rtl/png_chunk_deframer.sv -----
// PNG chunk deframer.
// Input channel: in_valid_i / in_stall_o carry one file byte per transfer
// (data_byte_i) with end_of_input_i marking the last byte of the file.
// Output channel: out_valid_o / out_stall_i carry one tagged byte per input
// byte: section, chunk length and type as assembled so far, the known-type
// code, the four property bits, chunk_end and truncated.
// The result of each byte is registered: a byte accepted in one cycle is shown in the next.
// Throughput is one byte per cycle while the receiver does not stall; the
// framing state updates in a single pass of logic into the output register.
// When the receiver stalls, the output register holds its result and the
// input is stalled only while that register is full and not being taken.
// Reset (rst_ni low, asynchronous) empties the output register and puts the
// framer at the start of the signature. A byte with end_of_input_i set also
// returns the framer to that state after its result is formed.
module png_chunk_deframer #(
  parameter int unsigned SIGNATURE_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  section_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] chunk_type_o,
  output logic [3:0]  type_code_o,
  output logic        ancillary_flag_o,
  output logic        private_flag_o,
  output logic        reserved_flag_o,
  output logic        safe_copy_flag_o,
  output logic        chunk_end_o,
  output logic        truncated_o
);

  logic            accept;
  logic            out_valid_q;
  pcd_pkg::step_t  step;
  pcd_pkg::class_t cls;

  // Stall only while a held result is not being taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  pcd_tracker #(
    .SIGNATURE_BYTES(SIGNATURE_BYTES)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_input_i(end_of_input_i),
    .step_o        (step)
  );

  pcd_classify u_classify (
    .chunk_type_i(step.chunk_type),
    .class_o     (cls)
  );

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Load the result register on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_out_o       <= data_byte_i;
      section_o        <= step.section;
      chunk_length_o   <= step.chunk_length;
      chunk_type_o     <= step.chunk_type;
      type_code_o      <= cls.type_code;
      ancillary_flag_o <= cls.ancillary;
      private_flag_o   <= cls.priv;
      reserved_flag_o  <= cls.reserved;
      safe_copy_flag_o <= cls.safe_copy;
      chunk_end_o      <= step.chunk_end;
      truncated_o      <= end_of_input_i & ~step.chunk_end;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/pcd_tracker.sv -----
module pcd_tracker #(
  parameter int unsigned SIGNATURE_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_input_i,
  output pcd_pkg::step_t     step_o
);

  localparam logic [2:0] SigLastPos = 3'(SIGNATURE_BYTES - 1);

  logic [2:0]  section_q, section_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] length_q, length_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] type_q, type_d;

  logic [31:0] remain_dec;
  logic [31:0] len_base;
  logic [31:0] type_base;

  assign remain_dec = (remain_q != 32'd0) ? (remain_q - 32'd1) : remain_q;
  // A new chunk starts on the first length byte: clear the assembled words
  assign len_base   = (pos_q == 3'd0) ? 32'd0 : length_q;
  assign type_base  = (pos_q == 3'd0) ? 32'd0 : type_q;

  // Advance the framing state by one byte
  always_comb begin
    section_d = section_q;
    pos_d     = pos_q;
    length_d  = length_q;
    remain_d  = remain_q;
    type_d    = type_q;
    step_o    = '0;
    case (section_q)
      pcd_pkg::SEC_LEN: begin
        length_d = {len_base[23:0], data_byte_i};
        type_d   = type_base;
        if (pos_q >= 3'd3) begin
          pos_d     = 3'd0;
          remain_d  = length_d;
          section_d = pcd_pkg::SEC_TYPE;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        step_o.section      = pcd_pkg::SEC_LEN;
        step_o.chunk_length = length_d;
        step_o.chunk_type   = type_d;
      end
      pcd_pkg::SEC_TYPE: begin
        type_d = {type_q[23:0], data_byte_i};
        if (pos_q >= 3'd3) begin
          pos_d     = 3'd0;
          section_d = (remain_q == 32'd0) ? pcd_pkg::SEC_CRC : pcd_pkg::SEC_DATA;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        step_o.section      = pcd_pkg::SEC_TYPE;
        step_o.chunk_length = length_q;
        step_o.chunk_type   = type_d;
      end
      pcd_pkg::SEC_DATA: begin
        remain_d = remain_dec;
        if (remain_dec == 32'd0) begin
          pos_d     = 3'd0;
          section_d = pcd_pkg::SEC_CRC;
        end
        step_o.section      = pcd_pkg::SEC_DATA;
        step_o.chunk_length = length_q;
        step_o.chunk_type   = type_q;
      end
      pcd_pkg::SEC_CRC: begin
        if (pos_q >= 3'd3) begin
          pos_d            = 3'd0;
          section_d        = pcd_pkg::SEC_LEN;
          step_o.chunk_end = 1'b1;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        step_o.section      = pcd_pkg::SEC_CRC;
        step_o.chunk_length = length_q;
        step_o.chunk_type   = type_q;
      end
      default: begin
        // Signature bytes pass through untouched
        if (pos_q >= SigLastPos) begin
          pos_d            = 3'd0;
          section_d        = pcd_pkg::SEC_LEN;
          step_o.chunk_end = 1'b1;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        step_o.section = pcd_pkg::SEC_SIG;
      end
    endcase
  end

  // Update state on each transfer; the last byte of the file returns to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q <= pcd_pkg::SEC_SIG;
      pos_q     <= 3'd0;
      length_q  <= 32'd0;
      remain_q  <= 32'd0;
      type_q    <= 32'd0;
    end else if (accept_i) begin
      if (end_of_input_i) begin
        section_q <= pcd_pkg::SEC_SIG;
        pos_q     <= 3'd0;
        length_q  <= 32'd0;
        remain_q  <= 32'd0;
        type_q    <= 32'd0;
      end else begin
        section_q <= section_d;
        pos_q     <= pos_d;
        length_q  <= length_d;
        remain_q  <= remain_d;
        type_q    <= type_d;
      end
    end
  end

endmodule

// ----- rtl/pcd_classify.sv -----
module pcd_classify (
  input  logic [31:0]     chunk_type_i,
  output pcd_pkg::class_t class_o
);

  // Match the type word against the known list; first hit wins
  always_comb begin
    class_o.type_code = pcd_pkg::TYPE_UNKNOWN;
    for (int i = pcd_pkg::NumKnown - 1; i >= 0; i--) begin
      if (chunk_type_i == pcd_pkg::KNOWN_TYPES[i]) begin
        class_o.type_code = 4'(i);
      end
    end
    class_o.ancillary = chunk_type_i[24 + pcd_pkg::PropBit];
    class_o.priv      = chunk_type_i[16 + pcd_pkg::PropBit];
    class_o.reserved  = chunk_type_i[8 + pcd_pkg::PropBit];
    class_o.safe_copy = chunk_type_i[pcd_pkg::PropBit];
  end

endmodule
